>>> sv/gdw_pkg.sv
// Shared types and constants of the grid ray walker.
package gdw_pkg;

	localparam int CELL_W  = 5;
	localparam int VALUE_W = 8;
	localparam int POS_W   = 21;
	localparam int DELTA_W = 32;
	localparam int SIDE_W  = 40;

	localparam logic [SIDE_W-1:0] SIDE_MAX = {SIDE_W{1'b1}};

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_CAST  = 1'b1;

	localparam logic SIDE_X = 1'b0;
	localparam logic SIDE_Y = 1'b1;

	typedef struct packed {
		logic               command;
		logic [CELL_W-1:0]  cell_x;
		logic [CELL_W-1:0]  cell_y;
		logic [VALUE_W-1:0] cell_value;
		logic [POS_W-1:0]   player_x;
		logic [POS_W-1:0]   player_y;
		logic               ray_x_negative;
		logic               ray_y_negative;
		logic [DELTA_W-1:0] delta_x;
		logic [DELTA_W-1:0] delta_y;
	} cmd_t;

	typedef struct packed {
		logic [CELL_W-1:0] hit_cell_x;
		logic [CELL_W-1:0] hit_cell_y;
		logic              hit_side;
		logic [SIDE_W-1:0] side_x;
		logic [SIDE_W-1:0] side_y;
		logic              escaped;
	} res_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL_X,
		ST_MUL_Y,
		ST_SAT_Y,
		ST_STEP
	} state_t;

endpackage

>>> sv/gdw_ram.sv
// Generic single write port, single read port RAM with registered read data.
module gdw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/grid_ray_dda_walker.sv
// Grid ray walker: map store plus a sequencer that steps a ray cell by cell.
// A write transaction is taken in the idle state without leaving it. A cast first
// passes through the setup states ST_MUL_X, ST_MUL_Y and ST_SAT_Y (two passes through
// one shared multiplier), then takes one cell step per cycle through a shared
// compare/add unit; the map read of each step is registered and checked for a wall
// in ST_STEP. The done strobe is registered. After reset the map is cleared, one cell
// a cycle, with busy high. Results cannot be stalled by the receiver.
module grid_ray_dda_walker #(
	parameter int MAP_WIDTH  = 32,
	parameter int MAP_HEIGHT = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  gdw_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done,
	output gdw_pkg::res_t result
);

	import gdw_pkg::*;

	localparam int DEPTH = MAP_WIDTH * MAP_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2((MAP_WIDTH > 32) ? MAP_WIDTH : 32) + 2;
	localparam int YW    = $clog2((MAP_HEIGHT > 32) ? MAP_HEIGHT : 32) + 2;
	localparam int OW    = (FRAC_BITS + 6 > POS_W) ? FRAC_BITS + 6 : POS_W;
	localparam int PW    = OW + DELTA_W;
	localparam int MW    = (PW > SIDE_W + 1) ? PW : SIDE_W + 1;

	// Offset from the player to the first cell boundary, clamped at zero.
	function automatic logic [OW-1:0] first_off(input logic [CELL_W-1:0] c,
			input logic [POS_W-1:0] p, input logic neg);
		logic [OW-1:0] pos;
		logic [OW-1:0] lo;
		logic [OW-1:0] hi;
		logic [OW-1:0] off;
		pos = OW'(p);
		lo  = OW'(c) << FRAC_BITS;
		hi  = lo + (OW'(1) << FRAC_BITS);
		if (neg) begin
			off = (pos >= lo) ? pos - lo : '0;
		end else begin
			off = (hi >= pos) ? hi - pos : '0;
		end
		return off;
	endfunction

	state_t state_q, state_d;
	logic [AW-1:0] clr_q;
	logic          pend_q;
	logic          done_q;

	logic [OW-1:0]      off_x_q, off_y_q;
	logic [DELTA_W-1:0] dx_q, dy_q;
	logic               xneg_q, yneg_q;
	logic signed [XW-1:0] mx_q;
	logic signed [YW-1:0] my_q;
	logic [SIDE_W-1:0]  sx_q, sy_q;
	logic               side_q;
	logic [PW-1:0]      prod_q;
	res_t               result_q;

	// Shared multiplier operands.
	logic [OW-1:0]      mul_a;
	logic [DELTA_W-1:0] mul_b;
	logic [MW-1:0]      prod_sh;
	logic [SIDE_W-1:0]  first_sat;

	// Shared step unit.
	logic               step_x;
	logic [SIDE_W-1:0]  add_a;
	logic [DELTA_W-1:0] add_b;
	logic [SIDE_W:0]    sum;
	logic [SIDE_W-1:0]  sum_sat;
	logic [SIDE_W-1:0]  nsx, nsy;
	logic signed [XW-1:0] nx;
	logic signed [YW-1:0] ny;
	logic               out_grid;
	logic               wall;

	logic               wr_in_grid;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [VALUE_W-1:0] mem_wdata;
	logic [AW-1:0]      rd_addr;
	logic [VALUE_W-1:0] rd_data;

	logic advance;
	logic finish;
	logic fin_esc;

	gdw_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(DEPTH)
	) u_map (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	assign mul_a     = (state_q == ST_MUL_X) ? off_x_q : off_y_q;
	assign mul_b     = (state_q == ST_MUL_X) ? dx_q : dy_q;
	assign prod_sh   = MW'(prod_q) >> FRAC_BITS;
	assign first_sat = (prod_sh > MW'(SIDE_MAX)) ? SIDE_MAX : prod_sh[SIDE_W-1:0];

	// Ties step in y.
	assign step_x  = (sx_q < sy_q);
	assign add_a   = step_x ? sx_q : sy_q;
	assign add_b   = step_x ? dx_q : dy_q;
	assign sum     = {1'b0, add_a} + (SIDE_W + 1)'(add_b);
	assign sum_sat = sum[SIDE_W] ? SIDE_MAX : sum[SIDE_W-1:0];
	assign nsx     = step_x ? sum_sat : sx_q;
	assign nsy     = step_x ? sy_q : sum_sat;

	always_comb begin
		nx = mx_q;
		ny = my_q;
		if (step_x) begin
			nx = xneg_q ? mx_q - XW'(1) : mx_q + XW'(1);
		end else begin
			ny = yneg_q ? my_q - YW'(1) : my_q + YW'(1);
		end
	end

	// A negative coordinate is caught by its sign bit; the bound compares are signed.
	assign out_grid = nx[XW-1] || ny[YW-1] || (nx >= XW'(MAP_WIDTH))
		|| (ny >= YW'(MAP_HEIGHT));
	assign rd_addr  = AW'(AW'(ny) * AW'(MAP_WIDTH)) + AW'(nx);
	assign wall     = pend_q && (rd_data != '0);

	assign wr_in_grid = (XW'(cmd.cell_x) < XW'(MAP_WIDTH))
		&& (YW'(cmd.cell_y) < YW'(MAP_HEIGHT));

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = AW'(AW'(cmd.cell_y) * AW'(MAP_WIDTH)) + AW'(cmd.cell_x);
		mem_wdata = cmd.cell_value;
		advance   = 1'b0;
		finish    = 1'b0;
		fin_esc   = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					if (cmd.command == CMD_CAST) begin
						state_d = ST_MUL_X;
					end else begin
						mem_we = wr_in_grid;
					end
				end
			end
			ST_MUL_X: state_d = ST_MUL_Y;
			ST_MUL_Y: state_d = ST_SAT_Y;
			ST_SAT_Y: state_d = ST_STEP;
			ST_STEP: begin
				if (wall) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					advance = 1'b1;
					if (out_grid) begin
						finish  = 1'b1;
						fin_esc = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			pend_q <= advance && !out_grid;
			done_q <= finish;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start && cmd.command == CMD_CAST) begin
			off_x_q <= first_off(cmd.cell_x, cmd.player_x, cmd.ray_x_negative);
			off_y_q <= first_off(cmd.cell_y, cmd.player_y, cmd.ray_y_negative);
			dx_q    <= cmd.delta_x;
			dy_q    <= cmd.delta_y;
			xneg_q  <= cmd.ray_x_negative;
			yneg_q  <= cmd.ray_y_negative;
			mx_q    <= XW'(cmd.cell_x);
			my_q    <= YW'(cmd.cell_y);
		end
		if (state_q == ST_MUL_X || state_q == ST_MUL_Y) begin
			prod_q <= PW'(mul_a) * PW'(mul_b);
		end
		if (state_q == ST_MUL_Y) begin
			sx_q <= first_sat;
		end
		if (state_q == ST_SAT_Y) begin
			sy_q <= first_sat;
		end
		if (advance) begin
			sx_q   <= nsx;
			sy_q   <= nsy;
			mx_q   <= nx;
			my_q   <= ny;
			side_q <= step_x ? SIDE_X : SIDE_Y;
		end
		if (finish) begin
			if (fin_esc) begin
				result_q.hit_cell_x <= '0;
				result_q.hit_cell_y <= '0;
				result_q.hit_side   <= step_x ? SIDE_X : SIDE_Y;
				result_q.side_x     <= nsx;
				result_q.side_y     <= nsy;
				result_q.escaped    <= 1'b1;
			end else begin
				result_q.hit_cell_x <= mx_q[CELL_W-1:0];
				result_q.hit_cell_y <= my_q[CELL_W-1:0];
				result_q.hit_side   <= side_q;
				result_q.side_x     <= sx_q;
				result_q.side_y     <= sy_q;
				result_q.escaped    <= 1'b0;
			end
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a cast in progress");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_no_result_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result strobe right after an accepted transaction");

	a_escape_zero_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.escaped) |-> (result.hit_cell_x == '0 && result.hit_cell_y == '0))
		else $error("escaped ray reports a nonzero cell");

	a_pending_only_stepping: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (state_q == ST_STEP))
		else $error("map read pending outside the stepping state");

endmodule

>>> sim/tb_grid_ray_dda_walker.sv
// Self-checking testbench for the grid ray walker: map writes and ray casts against a predictor.
module tb_grid_ray_dda_walker;
	timeunit 1ns;
	timeprecision 1ps;

	import gdw_pkg::*;

	localparam int MAP_W       = 32;
	localparam int MAP_H       = 32;
	localparam int FRAC        = 16;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_WAIT  = 80;
	localparam int RANDOM_PER_PHASE = 183;

	typedef struct {
		cmd_t c;
		bit   known;
		res_t want;
	} step_row_t;

	logic clk;
	logic arst_n;
	logic start;
	cmd_t cmd;
	logic busy;
	logic done;
	res_t result;

	logic [VALUE_W-1:0] wall_map [MAP_H][MAP_W];
	res_t      pending_hits[$];
	step_row_t script[$];
	int        mismatches   = 0;
	int        writes_sent  = 0;
	int        casts_sent   = 0;
	int        walls_seen   = 0;
	int        escapes_seen = 0;
	int        cycle_count  = 0;

	grid_ray_dda_walker uut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done),
		.result(result)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic cmd_t make_cast(logic [CELL_W-1:0] x, logic [CELL_W-1:0] y,
			logic [POS_W-1:0] px, logic [POS_W-1:0] py, logic xn, logic yn,
			logic [DELTA_W-1:0] dx, logic [DELTA_W-1:0] dy);
		cmd_t c;
		c = '0;
		c.command = CMD_CAST;
		c.cell_x = x;
		c.cell_y = y;
		c.player_x = px;
		c.player_y = py;
		c.ray_x_negative = xn;
		c.ray_y_negative = yn;
		c.delta_x = dx;
		c.delta_y = dy;
		return c;
	endfunction

	function automatic cmd_t make_write(logic [CELL_W-1:0] x, logic [CELL_W-1:0] y,
			logic [VALUE_W-1:0] v);
		cmd_t c;
		c = '0;
		c.command = CMD_WRITE;
		c.cell_x = x;
		c.cell_y = y;
		c.cell_value = v;
		return c;
	endfunction

	function automatic res_t make_res(logic [CELL_W-1:0] x, logic [CELL_W-1:0] y, logic s,
			logic [SIDE_W-1:0] sx, logic [SIDE_W-1:0] sy, logic esc);
		res_t r;
		r.hit_cell_x = x;
		r.hit_cell_y = y;
		r.hit_side = s;
		r.side_x = sx;
		r.side_y = sy;
		r.escaped = esc;
		return r;
	endfunction

	function automatic longint unsigned clip_side(longint unsigned v);
		return (v > longint'(SIDE_MAX)) ? longint'(SIDE_MAX) : v;
	endfunction

	// Distance from the player to the first cell border along one axis.
	function automatic longint unsigned first_side_dist(logic [CELL_W-1:0] cell_idx,
			logic [POS_W-1:0] pos, logic neg, logic [DELTA_W-1:0] delta);
		longint off;
		longint unsigned prod;
		if (neg)
			off = longint'(pos) - (longint'(cell_idx) << FRAC);
		else
			off = (longint'(cell_idx) << FRAC) + (longint'(1) << FRAC) - longint'(pos);
		if (off < 0)
			off = 0;
		prod = (longint'(unsigned'(off)) * longint'(delta)) >> FRAC;
		return clip_side(prod);
	endfunction

	function automatic res_t trace_ray(cmd_t c);
		longint unsigned sx;
		longint unsigned sy;
		int   mx;
		int   my;
		logic side;
		bit   esc;
		bit   walking;
		res_t r;
		sx = first_side_dist(c.cell_x, c.player_x, c.ray_x_negative, c.delta_x);
		sy = first_side_dist(c.cell_y, c.player_y, c.ray_y_negative, c.delta_y);
		mx = int'(c.cell_x);
		my = int'(c.cell_y);
		side = SIDE_X;
		esc = 1'b0;
		walking = 1'b1;
		// The start cell is never tested; every cast takes at least one step.
		while (walking) begin
			if (sx < sy) begin
				sx = clip_side(sx + c.delta_x);
				mx += c.ray_x_negative ? -1 : 1;
				side = SIDE_X;
			end else begin
				sy = clip_side(sy + c.delta_y);
				my += c.ray_y_negative ? -1 : 1;
				side = SIDE_Y;
			end
			if (mx < 0 || mx >= MAP_W || my < 0 || my >= MAP_H) begin
				esc = 1'b1;
				walking = 1'b0;
			end else if (wall_map[my][mx] != '0) begin
				walking = 1'b0;
			end
		end
		r.hit_cell_x = esc ? '0 : mx[CELL_W-1:0];
		r.hit_cell_y = esc ? '0 : my[CELL_W-1:0];
		r.hit_side = side;
		r.side_x = sx[SIDE_W-1:0];
		r.side_y = sy[SIDE_W-1:0];
		r.escaped = esc;
		return r;
	endfunction

	function automatic logic [DELTA_W-1:0] random_delta();
		case ($urandom_range(9))
			0: return '1;
			1: return '0;
			2, 3, 4: return $urandom;
			default: return $urandom_range(32'h0000_4000, 32'h0008_0000);
		endcase
	endfunction

	// Mostly casts from inside the start cell over a sparse map, with writes mixed in.
	function automatic cmd_t random_cmd();
		cmd_t c;
		c.command = ($urandom_range(99) < 30) ? CMD_WRITE : CMD_CAST;
		c.cell_x = CELL_W'($urandom);
		c.cell_y = CELL_W'($urandom);
		c.cell_value = $urandom_range(1) ? VALUE_W'($urandom_range(1, 255)) : '0;
		if ($urandom_range(4) != 0)
			c.player_x = {c.cell_x, 16'($urandom)};
		else
			c.player_x = POS_W'($urandom);
		if ($urandom_range(4) != 0)
			c.player_y = {c.cell_y, 16'($urandom)};
		else
			c.player_y = POS_W'($urandom);
		c.ray_x_negative = 1'($urandom_range(1));
		c.ray_y_negative = 1'($urandom_range(1));
		c.delta_x = random_delta();
		c.delta_y = random_delta();
		return c;
	endfunction

	function automatic int next_gap(int pct);
		int g;
		g = 0;
		while (g < 30 && $urandom_range(99) < pct)
			g++;
		return g;
	endfunction

	function automatic void add_row(cmd_t c, bit known, res_t want);
		step_row_t row;
		row.c = c;
		row.known = known;
		row.want = want;
		script.push_back(row);
	endfunction

	function automatic void build_script();
		// Empty map: a diagonal ray from the middle of the corner cell escapes at the top.
		add_row(make_cast(0, 0, 21'h08000, 21'h08000, 0, 0, 32'h10000, 32'h10000), 1,
			make_res(0, 0, SIDE_Y, 40'h1F8000, 40'h208000, 1));
		// Zero offsets with largest deltas: the tie steps y straight off the grid.
		add_row(make_cast(0, 0, 21'h0, 21'h0, 1, 1, '1, '1), 1,
			make_res(0, 0, SIDE_Y, 40'h0, 40'hFFFF_FFFF, 1));
		add_row(make_write(3, 0, 8'hFF), 0, '0);
		add_row(make_cast(0, 0, 21'h08000, 21'h08000, 0, 0, 32'h10000, '1), 1,
			make_res(3, 0, SIDE_X, 40'h38000, 40'h7FFF_FFFF, 0));
		add_row(make_cast(31, 31, '1, '1, 0, 0, 32'h10000, 32'h10000), 1,
			make_res(0, 0, SIDE_Y, 40'h1, 40'h10001, 1));
		add_row(make_cast(31, 31, '1, '1, 1, 1, 32'h10000, 32'h10000), 0, '0);
		add_row(make_write(3, 0, 8'h00), 0, '0);
		// Player outside the start cell: clamped offsets and offsets above one cell.
		add_row(make_cast(5, 5, 21'h0A0000, 21'h020000, 0, 0, 32'h20000, 32'h18000), 0, '0);
		add_row(make_cast(5, 5, 21'h0A0000, 21'h020000, 1, 1, 32'h20000, 32'h18000), 0, '0);
		add_row(make_write(10, 10, 8'h01), 0, '0);
		add_row(make_write(12, 10, 8'h80), 0, '0);
		// The start cell holds a wall, which must not stop the ray.
		add_row(make_cast(10, 10, 21'h0A8000, 21'h0A8000, 0, 1, 32'h10000, '1), 0, '0);
		add_row(make_cast(10, 20, 21'h0A4000, 21'h144000, 0, 0, '0, '0), 0, '0);
		add_row(make_cast(20, 4, 21'h140000, 21'h04C000, 1, 0, '0, 32'h30000), 0, '0);
		add_row(make_write(31, 0, 8'hAA), 0, '0);
		add_row(make_write(0, 31, 8'h55), 0, '0);
		add_row(make_cast(0, 0, 21'h0C000, 21'h04000, 0, 0, 32'h8000, '1), 0, '0);
		add_row(make_cast(0, 0, 21'h04000, 21'h0C000, 0, 0, '1, 32'h8000), 0, '0);
		add_row(make_cast(0, 15, 21'h02000, 21'h0F8000, 1, 0, 32'h1_2345, '1), 0, '0);
		add_row(make_cast(17, 9, 21'h11_7FFF, 21'h09_0001, 1, 0, 32'h0001_8000,
			32'h0002_4000), 0, '0);
	endfunction

	task automatic send_item(input cmd_t c, input bit known, input res_t typed, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= c;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (c.command == CMD_WRITE) begin
			wall_map[c.cell_y][c.cell_x] = c.cell_value;
			writes_sent++;
		end else begin
			pending_hits.push_back(known ? typed : trace_ray(c));
			casts_sent++;
		end
	endtask

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && done) begin
			if (pending_hits.size() == 0) begin
				$error("result transaction with no cast waiting for it");
				mismatches++;
			end else begin
				want = pending_hits.pop_front();
				check_field("hit_cell_x", 64'(want.hit_cell_x), 64'(result.hit_cell_x));
				check_field("hit_cell_y", 64'(want.hit_cell_y), 64'(result.hit_cell_y));
				check_field("hit_side", 64'(want.hit_side), 64'(result.hit_side));
				check_field("side_x", 64'(want.side_x), 64'(result.side_x));
				check_field("side_y", 64'(want.side_y), 64'(result.side_y));
				check_field("escaped", 64'(want.escaped), 64'(result.escaped));
				if (want.escaped)
					escapes_seen++;
				else
					walls_seen++;
			end
		end
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles, %0d casts still outstanding",
			cycle_count, pending_hits.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int gap_pct;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		foreach (wall_map[y, x])
			wall_map[y][x] = '0;
		build_script();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		foreach (script[i])
			send_item(script[i].c, script[i].known, script[i].want, next_gap(38));
		// Sender pacing: sparse gaps, then frequent gaps, then back to back.
		for (int phase = 0; phase < 3; phase++) begin
			gap_pct = (phase == 0) ? 38 : (phase == 1) ? 79 : 0;
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				send_item(random_cmd(), 1'b0, '0, next_gap(gap_pct));
		end
		start <= 1'b0;
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("Sent %0d map writes and %0d ray casts under three sender pacings.",
			writes_sent, casts_sent);
		$display("Rays ending on a wall: %0d, rays leaving the grid: %0d, mismatches: %0d.",
			walls_seen, escapes_seen, mismatches);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
